### hdl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle, ignored while in reset.
`define IIBS_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define IIBS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/iibs_pkg.sv
// Shared types and constants of the integral image box-sum block.
package iibs_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W  = 8;
  localparam int VAL_W  = 22;
  localparam int PIX_W  = 8;
  localparam int RSUM_W = $clog2(MAX_WIDTH * 255 + 1);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // pixel: addr0 = entry above, addr1 = entry written
  // query: addr0..addr3 = top-left, bottom-right, bottom-left, top-right
  typedef struct packed {
    logic              is_query;
    logic              oor;
    logic              done;
    logic              has_above;
    logic [RSUM_W-1:0] rsum;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [ADDR_W-1:0] addr3;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             oor;
    logic             done;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PIX,
    BK_Q1,
    BK_Q2,
    BK_Q3,
    BK_Q4
  } bk_state_t;

endpackage

### hdl/integral_image_box_sum.sv
// Top level of the integral image builder with rectangle box-sum queries.
// A pixel passes through the command queue, then the store engine's idle and write-back states;
// an in-frame query passes through idle and four read states, and an out-of-frame query is
// answered from the idle state. The store engine takes one command at a time, and only while
// the result queue has room, so a new command waits in the queue until the engine is idle.
// Reset (rst_n low, synchronous): raster position, row sum and both queues cleared, frame 128 x 128.
module integral_image_box_sum import iibs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_mode,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic [COL_W-1:0]      in_rect_left,
  input  logic [ROW_W-1:0]      in_rect_upper,
  input  logic [DIM_W-1:0]      in_rect_width,
  input  logic [DIM_W-1:0]      in_rect_height,
  output logic                  empty,
  input  logic                  pop,
  output logic [VAL_W-1:0]      out_result_value,
  output logic                  out_out_of_range,
  output logic                  out_frame_complete,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic [DIM_W-1:0] fw_r, fh_r;
  logic             cmd_push, cmd_pop, cmd_valid;
  cmd_t             cmd_in, cmd_out;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= DIM_W'(128);
      fh_r <= DIM_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= DIM_W'(cfg_data);
        CFG_FRAME_HEIGHT: fh_r <= DIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  iibs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (push),
    .room           (!full),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .in_rect_left   (in_rect_left),
    .in_rect_upper  (in_rect_upper),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .frame_width    (fw_r),
    .frame_height   (fh_r),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  iibs_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .valid   (cmd_valid)
  );

  iibs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_result_value   = res.value;
  assign out_out_of_range   = res.oor;
  assign out_frame_complete = res.done;

  `IIBS_ASSERT_SAME(a_oor_zero, clk, rst_n, !empty && out_out_of_range, out_result_value == '0, "out-of-range item carries a non-zero value")
  `IIBS_ASSERT_SAME(a_flags_excl, clk, rst_n, !empty, !(out_out_of_range && out_frame_complete), "item flagged both out of range and frame end")
  `IIBS_ASSERT_SAME(a_pop_valid, clk, rst_n, cmd_pop, cmd_valid, "store engine took a command from an empty queue")
  `IIBS_ASSERT_NEXT(a_push_cmd, clk, rst_n, push && !full && !cmd_pop, cmd_valid, "accepted item did not reach the command queue")

endmodule

### hdl/iibs_front.sv
// Front end: raster tracking, row sum, rectangle checks and store addresses.
module iibs_front import iibs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 room,
  input  logic                 in_mode,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic [COL_W-1:0]     in_rect_left,
  input  logic [ROW_W-1:0]     in_rect_upper,
  input  logic [DIM_W-1:0]     in_rect_width,
  input  logic [DIM_W-1:0]     in_rect_height,
  input  logic [DIM_W-1:0]     frame_width,
  input  logic [DIM_W-1:0]     frame_height,
  output logic                 cmd_push,
  output cmd_t                 cmd
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [RSUM_W-1:0] row_sum_r, row_sum_nxt;

  logic [DIM_W-1:0]  fw, fh;
  logic              last_col, last_row;
  logic [RSUM_W-1:0] rsum;
  logic [DIM_W:0]    lw, uh;
  logic [COL_W-1:0]  right;
  logic [ROW_W-1:0]  lower;
  logic              pix_acc;

  assign fw = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign fh = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));

  assign cmd_push = in_valid && room;
  assign pix_acc  = cmd_push && !in_mode;

  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= fw;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= fh;
  assign rsum     = ((col_r == '0) ? '0 : row_sum_r) + RSUM_W'(in_pixel);

  assign lw    = (DIM_W+1)'(in_rect_left) + (DIM_W+1)'(in_rect_width);
  assign uh    = (DIM_W+1)'(in_rect_upper) + (DIM_W+1)'(in_rect_height);
  assign right = COL_W'(lw - (DIM_W+1)'(1));
  assign lower = ROW_W'(uh - (DIM_W+1)'(1));

  always_comb begin
    cmd = '0;
    cmd.is_query = in_mode;
    if (in_mode) begin
      cmd.oor   = (in_rect_width == '0) || (in_rect_height == '0) ||
                  (lw > (DIM_W+1)'(fw)) || (uh > (DIM_W+1)'(fh));
      cmd.addr0 = {in_rect_upper, in_rect_left};
      cmd.addr1 = {lower, right};
      cmd.addr2 = {lower, in_rect_left};
      cmd.addr3 = {in_rect_upper, right};
    end else begin
      cmd.done      = last_col && last_row;
      cmd.has_above = (row_r != '0);
      cmd.rsum      = rsum;
      cmd.addr0     = {row_r - ROW_W'(1), col_r};
      cmd.addr1     = {row_r, col_r};
    end
  end

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    row_sum_nxt = row_sum_r;
    if (pix_acc) begin
      row_sum_nxt = rsum;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      row_sum_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      row_sum_r <= row_sum_nxt;
    end
  end

endmodule

### hdl/iibs_cmd_fifo.sv
// Short command queue between the front end and the store engine.
module iibs_cmd_fifo import iibs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic valid
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slot_r [CMD_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(CMD_DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + PTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wp_r] <= wr_data;
  end

endmodule

### hdl/iibs_back.sv
// Store engine: integral store, pixel write-back, four-corner box sums, result queue.
module iibs_back import iibs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output res_t res
);

  localparam int RPTR_W = $clog2(RES_DEPTH);
  localparam int RCNT_W = $clog2(RES_DEPTH + 1);

  bk_state_t        state_r, state_nxt;
  cmd_t             cur_r;
  logic [VAL_W-1:0] acc_r, acc_nxt;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [VAL_W-1:0]  wdata;

  res_t              res_slot_r [RES_DEPTH];
  logic [RPTR_W-1:0] res_wp_r, res_rp_r;
  logic [RCNT_W-1:0] res_cnt_r;
  logic              res_push, res_pop, res_room;
  res_t              res_in;

  assign res_room = (res_cnt_r != RCNT_W'(RES_DEPTH));
  assign empty    = (res_cnt_r == '0);
  assign res_pop  = pop && !empty;
  assign res      = res_slot_r[res_rp_r];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && res_room) begin
          if (!cmd.is_query) state_nxt = BK_PIX;
          else if (!cmd.oor) state_nxt = BK_Q1;
        end
      end
      BK_PIX: state_nxt = BK_IDLE;
      BK_Q1:  state_nxt = BK_Q2;
      BK_Q2:  state_nxt = BK_Q3;
      BK_Q3:  state_nxt = BK_Q4;
      BK_Q4:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    raddr    = cur_r.addr0;
    we       = 1'b0;
    wdata    = VAL_W'(cur_r.rsum) + (cur_r.has_above ? rd_data_r : '0);
    acc_nxt  = acc_r;
    res_push = 1'b0;
    res_in   = '0;
    unique case (state_r)
      BK_IDLE: begin
        raddr = cmd.addr0;
        if (cmd_valid && res_room) begin
          cmd_pop = 1'b1;
          if (cmd.is_query && cmd.oor) begin
            res_push   = 1'b1;
            res_in.oor = 1'b1;
          end
        end
      end
      BK_PIX: begin
        we           = 1'b1;
        res_push     = 1'b1;
        res_in.value = wdata;
        res_in.done  = cur_r.done;
      end
      BK_Q1: begin
        raddr   = cur_r.addr1;
        acc_nxt = rd_data_r;
      end
      BK_Q2: begin
        raddr   = cur_r.addr2;
        acc_nxt = acc_r + rd_data_r;
      end
      BK_Q3: begin
        raddr   = cur_r.addr3;
        acc_nxt = acc_r - rd_data_r;
      end
      BK_Q4: begin
        res_push     = 1'b1;
        res_in.value = acc_r - rd_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[cur_r.addr1] <= wdata;
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= '0;
      res_rp_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) res_wp_r <= res_wp_r + RPTR_W'(1);
      if (res_pop)  res_rp_r <= res_rp_r + RPTR_W'(1);
      res_cnt_r <= res_cnt_r + RCNT_W'(res_push) - RCNT_W'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_slot_r[res_wp_r] <= res_in;
  end

endmodule
